@@ rtl/rhc_pkg.sv @@
// Package for the reference-counted hash cache with release queue.
// Holds default sizes, command and status codes and output field helpers.
// No dependencies; used by the top level.
package rhc_pkg;

   localparam int DEF_SLOTS   = 1024;
   localparam int DEF_BUCKETS = 256;
   localparam int DEF_REF_BITS = 16;

   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 11;
   localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 11'd1024;

   localparam logic CMD_GET     = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_FULL    = 3'd2,
      ST_HELD    = 3'd3,
      ST_QUEUED  = 3'd4,
      ST_EVICTED = 3'd5,
      ST_ERROR   = 3'd6
   } status_type;

   // Slot numbers are reported in ten bits.
   function automatic logic [INDEX_W-1:0] fit_index(input logic [31:0] value);
      return value[INDEX_W-1:0];
   endfunction

   // Reference counts are reported in sixteen bits.
   function automatic logic [COUNT_W-1:0] fit_count(input logic [31:0] value);
      return value[COUNT_W-1:0];
   endfunction

endpackage

@@ rtl/rhc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port.
// The read data is registered. No dependencies.
module rhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/refcounted_hash_cache_with_release_fifo_unit.sv @@
// Reference-counted hash cache with a release queue, built around block RAMs.
// A get computes the bucket number, reads the bucket head and compares the chain entries in
// turn; a hit on an unreferenced entry takes it out of the release queue, and a miss takes the
// lowest free slot. A release that brings a count to zero queues the slot; at the queue limit the
// oldest entry is evicted and unlinked from its chain. Reset is synchronous; a clearing pass
// over the bucket heads and valid words follows. One request at a time.
module refcounted_hash_cache_with_release_fifo_unit
   import rhc_pkg::*;
#(
   parameter int SLOTS    = DEF_SLOTS,
   parameter int BUCKETS  = DEF_BUCKETS,
   parameter int REF_BITS = DEF_REF_BITS
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // lookup_key[63:0], key_hash[95:64], entry_index[105:96]
   input  logic         req_tuser,  // command
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // result_index[9:0], evicted_index[19:10],
                                    // reference_count[35:20]
   output logic [2:0]   rsp_tuser,  // status
   // Configuration write: release_queue_limit.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [10:0]  csr_wdata
);

   // Slot and link widths. A link holds a slot number or the null value SLOTS.
   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW = $clog2(BUCKETS) + 1;
   localparam bit BPOW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   // Reciprocal of BUCKETS; the quotient estimate it gives is never more than one short.
   localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << 32) / 64'(BUCKETS));
   // The valid bits are kept as words of VW bits, with one "word full" flop per word.
   localparam int VB = (IW < 5) ? IW : 5;
   localparam int VW = 1 << VB;
   localparam int NWORDS = (SLOTS + VW - 1) / VW;
   localparam int WW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CLRN = (BUCKETS > NWORDS) ? BUCKETS : NWORDS;
   localparam int CCW = $clog2(CLRN + 1);
   // Slot word: key, hash, reference count, chain link.
   localparam int SW = KEY_W + HASH_W + REF_BITS + LW;
   localparam int OFS_REFS = KEY_W + HASH_W;
   localparam int OFS_NEXT = KEY_W + HASH_W + REF_BITS;
   localparam logic [LW-1:0] NIL = LW'(SLOTS);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   typedef enum logic [24:0] {
      S_CLEAR  = 25'b1 << 0,
      S_IDLE   = 25'b1 << 1,
      S_MOD    = 25'b1 << 2,
      S_G_BRD  = 25'b1 << 3,
      S_G_BDAT = 25'b1 << 4,
      S_G_CMP  = 25'b1 << 5,
      S_H_WR   = 25'b1 << 6,
      S_QR_RD  = 25'b1 << 7,
      S_QR_WR  = 25'b1 << 8,
      S_M_SUM  = 25'b1 << 9,
      S_M_VAL  = 25'b1 << 10,
      S_M_LNK  = 25'b1 << 11,
      S_R_RD   = 25'b1 << 12,
      S_R_CHK  = 25'b1 << 13,
      S_P_LINK = 25'b1 << 14,
      S_P_TAIL = 25'b1 << 15,
      S_E_SRD  = 25'b1 << 16,
      S_E_SDAT = 25'b1 << 17,
      S_E_BRD  = 25'b1 << 18,
      S_E_BDAT = 25'b1 << 19,
      S_E_CHK  = 25'b1 << 20,
      S_E_WDAT = 25'b1 << 21,
      S_E_VRD  = 25'b1 << 22,
      S_E_VWR  = 25'b1 << 23,
      S_RESP   = 25'b1 << 24
   } state_type;

   // Control registers.
   state_type          state_ff, state_in;
   logic [CCW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LW-1:0]      newest_ff, newest_in;
   logic [LW-1:0]      oldest_ff, oldest_in;
   logic [LW-1:0]      count_ff, count_in;
   logic [NWORDS-1:0]  full_ff, full_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers of the request in flight.
   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [HASH_W-1:0]  hsel_ff, hsel_in;
   logic [4:0]         mcnt_ff, mcnt_in;
   logic [HASH_W-1:0]  quo_ff, quo_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [BW-1:0]      bucket_ff, bucket_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      last_ff, last_in;
   logic [SW-1:0]      word_ff, word_in;
   logic [IW-1:0]      qidx_ff, qidx_in;
   logic [IW-1:0]      eidx_ff, eidx_in;
   logic [IW-1:0]      newidx_ff, newidx_in;
   logic [LW-1:0]      vnext_ff, vnext_in;
   logic [WW-1:0]      wsel_ff, wsel_in;

   // Pending result and output register.
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [INDEX_W-1:0]  res_ri_ff, res_ri_in;
   logic [INDEX_W-1:0]  res_ei_ff, res_ei_in;
   logic [COUNT_W-1:0]  res_rc_ff, res_rc_in;
   logic [STATUS_W-1:0] out_st_ff, out_st_in;
   logic [INDEX_W-1:0]  out_ri_ff, out_ri_in;
   logic [INDEX_W-1:0]  out_ei_ff, out_ei_in;
   logic [COUNT_W-1:0]  out_rc_ff, out_rc_in;

   // RAM ports: slot words, bucket heads, valid words, queue newer and older links.
   logic          s_we;
   logic [IW-1:0] s_wa, s_ra;
   logic [SW-1:0] s_wd, s_rd;
   logic          b_we;
   logic [BW-1:0] b_wa, b_ra;
   logic [LW-1:0] b_wd, b_rd;
   logic          v_we;
   logic [WW-1:0] v_wa, v_ra;
   logic [VW-1:0] v_wd, v_rd;
   logic          n_we;
   logic [IW-1:0] n_wa, n_ra;
   logic [LW-1:0] n_wd, n_rd;
   logic          o_we;
   logic [IW-1:0] o_wa, o_ra;
   logic [LW-1:0] o_wd, o_rd;

   rhc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   rhc_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   rhc_ram #(.WIDTH(VW), .DEPTH(NWORDS)) u_valid_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));
   rhc_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_newer_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(n_ra), .rd_data(n_rd));
   rhc_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_older_ram (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd));

   // Fields of the slot word coming out of the slot RAM.
   logic [KEY_W-1:0]    rd_key;
   logic [HASH_W-1:0]   rd_hash;
   logic [REF_BITS-1:0] rd_refs;
   logic [LW-1:0]       rd_next;
   assign rd_key  = s_rd[KEY_W-1:0];
   assign rd_hash = s_rd[KEY_W +: HASH_W];
   assign rd_refs = s_rd[OFS_REFS +: REF_BITS];
   assign rd_next = s_rd[OFS_NEXT +: LW];

   // Lowest word that still has a free slot.
   logic          sum_found;
   logic [WW-1:0] sum_idx;
   always_comb begin
      sum_found = 1'b0;
      sum_idx   = '0;
      for (int k = NWORDS - 1; k >= 0; k--) begin
         if (!full_ff[k]) begin
            sum_found = 1'b1;
            sum_idx   = WW'(k);
         end
      end
   end

   // Lowest free bit within the valid word just read.
   logic          bit_found;
   logic [VB-1:0] bit_idx;
   always_comb begin
      bit_found = 1'b0;
      bit_idx   = '0;
      for (int k = VW - 1; k >= 0; k--) begin
         if (!v_rd[k]) begin
            bit_found = 1'b1;
            bit_idx   = VB'(k);
         end
      end
   end

   // Remainder by BUCKETS: the quotient estimate from the reciprocal, then the hash
   // minus estimate times BUCKETS, which is below twice BUCKETS.
   logic [63:0]       recip_prod;
   logic [HASH_W-1:0] quo_back;
   assign recip_prod = 64'(hsel_ff) * 64'(RECIP);
   assign quo_back   = quo_ff * HASH_W'(BUCKETS);

   logic [31:0] new_slot;
   logic [VW-1:0] v_set;
   logic [REF_BITS-1:0] refs_dec;
   assign new_slot = (32'(sum_idx) << VB) | 32'(bit_idx);
   assign v_set    = v_rd | (VW'(1) << bit_idx);
   assign refs_dec = rd_refs - REF_BITS'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      limit_in     = limit_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      hsel_in      = hsel_ff;
      mcnt_in      = mcnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      bucket_in    = bucket_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      qidx_in      = qidx_ff;
      eidx_in      = eidx_ff;
      newidx_in    = newidx_ff;
      vnext_in     = vnext_ff;
      wsel_in      = wsel_ff;
      res_st_in    = res_st_ff;
      res_ri_in    = res_ri_ff;
      res_ei_in    = res_ei_ff;
      res_rc_in    = res_rc_ff;
      out_st_in    = out_st_ff;
      out_ri_in    = out_ri_ff;
      out_ei_in    = out_ei_ff;
      out_rc_in    = out_rc_ff;

      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
      b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
      v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
      n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
      o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;

      if (csr_valid) begin
         limit_in = csr_wdata;
      end

      // The output register drains independently of the request in flight.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Empty the bucket heads and valid words, one entry of each per cycle.
         S_CLEAR: begin
            if (32'(clr_cnt_ff) < BUCKETS) begin
               b_we = 1'b1;
               b_wa = BW'(clr_cnt_ff);
               b_wd = NIL;
            end
            if (32'(clr_cnt_ff) < NWORDS) begin
               v_we = 1'b1;
               v_wa = WW'(clr_cnt_ff);
               v_wd = '0;
            end
            clr_cnt_in = clr_cnt_ff + CCW'(1);
            if (32'(clr_cnt_ff) == CLRN - 1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               key_in  = req_tdata[63:0];
               hash_in = req_tdata[95:64];
               hsel_in = req_tdata[95:64];
               mcnt_in = 5'd2;
               rem_in  = '0;
               eidx_in = IW'(req_tdata[105:96]);
               if (req_tuser == CMD_GET) begin
                  state_in = S_MOD;
               end else if (32'(req_tdata[105:96]) >= SLOTS) begin
                  // Out-of-range slot: nothing changes.
                  res_st_in = ST_ERROR;
                  res_ri_in = '0;
                  res_ei_in = '0;
                  res_rc_in = '0;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_R_RD;
               end
            end
         end

         // Bucket number of hsel: a mask for a power of two, else a reciprocal multiply, a
         // back-multiply and one conditional subtract, in turn.
         S_MOD: begin
            if (BPOW2) begin
               bucket_in = BW'(hsel_ff & 32'(BUCKETS - 1));
               state_in  = (cmd_ff == CMD_GET) ? S_G_BRD : S_E_BRD;
            end else begin
               mcnt_in = mcnt_ff - 5'd1;
               if (mcnt_ff == 5'd2) begin
                  quo_in = recip_prod[63:32];
               end else if (mcnt_ff == 5'd1) begin
                  rem_in = RW'(hsel_ff - quo_back);
               end else begin
                  if (32'(rem_ff) >= 32'(BUCKETS)) begin
                     bucket_in = BW'(32'(rem_ff) - 32'(BUCKETS));
                  end else begin
                     bucket_in = BW'(rem_ff);
                  end
                  state_in = (cmd_ff == CMD_GET) ? S_G_BRD : S_E_BRD;
               end
            end
         end

         S_G_BRD: begin
            b_ra     = bucket_ff;
            state_in = S_G_BDAT;
         end

         S_G_BDAT: begin
            last_in = NIL;
            if (b_rd == NIL) begin
               state_in = S_M_SUM;
            end else begin
               s_ra     = IW'(b_rd);
               cur_in   = b_rd;
               state_in = S_G_CMP;
            end
         end

         // Chain walk: one slot word compared per cycle, the next read issued at once.
         S_G_CMP: begin
            if (rd_hash == hash_ff && rd_key == key_ff) begin
               if (rd_refs == REF_MAX) begin
                  res_st_in = ST_ERROR;
                  res_ri_in = fit_index(32'(cur_ff));
                  res_ei_in = '0;
                  res_rc_in = fit_count(32'(rd_refs));
                  state_in  = S_RESP;
               end else begin
                  word_in = s_rd;
                  word_in[OFS_REFS +: REF_BITS] = rd_refs + REF_BITS'(1);
                  if (rd_refs == '0) begin
                     qidx_in  = IW'(cur_ff);
                     state_in = S_QR_RD;
                  end else begin
                     state_in = S_H_WR;
                  end
               end
            end else begin
               last_in = cur_ff;
               word_in = s_rd;
               if (rd_next == NIL) begin
                  state_in = S_M_SUM;
               end else begin
                  s_ra   = IW'(rd_next);
                  cur_in = rd_next;
               end
            end
         end

         S_H_WR: begin
            s_we      = 1'b1;
            s_wa      = IW'(cur_ff);
            s_wd      = word_ff;
            res_st_in = ST_HIT;
            res_ri_in = fit_index(32'(cur_ff));
            res_ei_in = '0;
            res_rc_in = fit_count(32'(word_ff[OFS_REFS +: REF_BITS]));
            state_in  = S_RESP;
         end

         // Unlink qidx from the release queue.
         S_QR_RD: begin
            n_ra     = qidx_ff;
            o_ra     = qidx_ff;
            state_in = S_QR_WR;
         end

         S_QR_WR: begin
            if (n_rd != NIL) begin
               o_we = 1'b1;
               o_wa = IW'(n_rd);
               o_wd = o_rd;
            end else begin
               newest_in = o_rd;
            end
            if (o_rd != NIL) begin
               n_we = 1'b1;
               n_wa = IW'(o_rd);
               n_wd = n_rd;
            end else begin
               oldest_in = n_rd;
            end
            if (cmd_ff == CMD_GET) begin
               if (count_ff != '0) begin
                  count_in = count_ff - LW'(1);
               end
               state_in = S_H_WR;
            end else begin
               state_in = S_E_SRD;
            end
         end

         // Miss: find the lowest free slot.
         S_M_SUM: begin
            if (!sum_found) begin
               res_st_in = ST_FULL;
               res_ri_in = '0;
               res_ei_in = '0;
               res_rc_in = '0;
               state_in  = S_RESP;
            end else begin
               v_ra     = sum_idx;
               wsel_in  = sum_idx;
               state_in = S_M_VAL;
            end
         end

         S_M_VAL: begin
            // Bits past the last slot read as free; an index there means the table is full.
            if (!bit_found || (((32'(wsel_ff) << VB) | 32'(bit_idx)) >= SLOTS)) begin
               res_st_in = ST_FULL;
               res_ri_in = '0;
               res_ei_in = '0;
               res_rc_in = '0;
               state_in  = S_RESP;
            end else begin
               v_we = 1'b1;
               v_wa = wsel_ff;
               v_wd = v_set;
               full_in[wsel_ff] = &v_set;
               newidx_in = IW'((32'(wsel_ff) << VB) | 32'(bit_idx));
               s_we = 1'b1;
               s_wa = IW'((32'(wsel_ff) << VB) | 32'(bit_idx));
               s_wd = {NIL, REF_BITS'(1), hash_ff, key_ff};
               res_st_in = ST_MISS;
               res_ri_in = fit_index((32'(wsel_ff) << VB) | 32'(bit_idx));
               res_ei_in = '0;
               res_rc_in = COUNT_W'(1);
               if (last_ff == NIL) begin
                  b_we     = 1'b1;
                  b_wa     = bucket_ff;
                  b_wd     = LW'((32'(wsel_ff) << VB) | 32'(bit_idx));
                  state_in = S_RESP;
               end else begin
                  state_in = S_M_LNK;
               end
            end
         end

         // Append the new slot behind the chain's last entry.
         S_M_LNK: begin
            s_we = 1'b1;
            s_wa = IW'(last_ff);
            s_wd = word_ff;
            s_wd[OFS_NEXT +: LW] = LW'(newidx_ff);
            state_in = S_RESP;
         end

         S_R_RD: begin
            s_ra     = eidx_ff;
            v_ra     = WW'(eidx_ff >> VB);
            state_in = S_R_CHK;
         end

         S_R_CHK: begin
            if (!v_rd[VB'(eidx_ff)] || rd_refs == '0) begin
               res_st_in = ST_ERROR;
               res_ri_in = '0;
               res_ei_in = '0;
               res_rc_in = '0;
               state_in  = S_RESP;
            end else begin
               s_we = 1'b1;
               s_wa = eidx_ff;
               s_wd = s_rd;
               s_wd[OFS_REFS +: REF_BITS] = refs_dec;
               if (refs_dec != '0) begin
                  res_st_in = ST_HELD;
                  res_ri_in = '0;
                  res_ei_in = '0;
                  res_rc_in = fit_count(32'(refs_dec));
                  state_in  = S_RESP;
               end else begin
                  state_in = S_P_LINK;
               end
            end
         end

         // Push the released slot at the newest end of the queue.
         S_P_LINK: begin
            o_we = 1'b1;
            o_wa = eidx_ff;
            o_wd = newest_ff;
            if (newest_ff != NIL) begin
               n_we = 1'b1;
               n_wa = IW'(newest_ff);
               n_wd = LW'(eidx_ff);
            end else begin
               oldest_in = LW'(eidx_ff);
            end
            newest_in = LW'(eidx_ff);
            state_in  = S_P_TAIL;
         end

         S_P_TAIL: begin
            n_we = 1'b1;
            n_wa = eidx_ff;
            n_wd = NIL;
            if (32'(count_ff) < 32'(limit_ff)) begin
               count_in  = count_ff + LW'(1);
               res_st_in = ST_QUEUED;
               res_ri_in = '0;
               res_ei_in = '0;
               res_rc_in = '0;
               state_in  = S_RESP;
            end else begin
               // The oldest entry leaves; if the queue was empty, that is the one just pushed.
               qidx_in  = IW'(oldest_ff);
               state_in = S_QR_RD;
            end
         end

         // Eviction: fetch the victim's hash and link, then unlink it from its chain and clear its valid bit.
         S_E_SRD: begin
            s_ra     = qidx_ff;
            state_in = S_E_SDAT;
         end

         S_E_SDAT: begin
            vnext_in = rd_next;
            hsel_in  = rd_hash;
            mcnt_in  = 5'd2;
            rem_in   = '0;
            state_in = S_MOD;
         end

         S_E_BRD: begin
            b_ra     = bucket_ff;
            state_in = S_E_BDAT;
         end

         S_E_BDAT: begin
            cur_in   = b_rd;
            last_in  = NIL;
            state_in = S_E_CHK;
         end

         S_E_CHK: begin
            if (cur_ff == NIL) begin
               state_in = S_E_VRD;
            end else if (cur_ff == LW'(qidx_ff)) begin
               if (last_ff == NIL) begin
                  b_we = 1'b1;
                  b_wa = bucket_ff;
                  b_wd = vnext_ff;
               end else begin
                  s_we = 1'b1;
                  s_wa = IW'(last_ff);
                  s_wd = word_ff;
                  s_wd[OFS_NEXT +: LW] = vnext_ff;
               end
               state_in = S_E_VRD;
            end else begin
               s_ra     = IW'(cur_ff);
               state_in = S_E_WDAT;
            end
         end

         S_E_WDAT: begin
            last_in  = cur_ff;
            word_in  = s_rd;
            cur_in   = rd_next;
            state_in = S_E_CHK;
         end

         S_E_VRD: begin
            v_ra     = WW'(qidx_ff >> VB);
            state_in = S_E_VWR;
         end

         S_E_VWR: begin
            v_we = 1'b1;
            v_wa = WW'(qidx_ff >> VB);
            v_wd = v_rd & ~(VW'(1) << VB'(qidx_ff));
            full_in[WW'(qidx_ff >> VB)] = 1'b0;
            res_st_in = ST_EVICTED;
            res_ri_in = '0;
            res_ei_in = fit_index(32'(qidx_ff));
            res_rc_in = '0;
            state_in  = S_RESP;
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_st_in    = res_st_ff;
               out_ri_in    = res_ri_ff;
               out_ei_in    = res_ei_ff;
               out_rc_in    = res_rc_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         limit_ff     <= QUEUE_LIMIT_RESET;
         newest_ff    <= NIL;
         oldest_ff    <= NIL;
         count_ff     <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         limit_ff     <= limit_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      hash_ff   <= hash_in;
      hsel_ff   <= hsel_in;
      mcnt_ff   <= mcnt_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      bucket_ff <= bucket_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      word_ff   <= word_in;
      qidx_ff   <= qidx_in;
      eidx_ff   <= eidx_in;
      newidx_ff <= newidx_in;
      vnext_ff  <= vnext_in;
      wsel_ff   <= wsel_in;
      res_st_ff <= res_st_in;
      res_ri_ff <= res_ri_in;
      res_ei_ff <= res_ei_in;
      res_rc_ff <= res_rc_in;
      out_st_ff <= out_st_in;
      out_ri_ff <= out_ri_in;
      out_ei_ff <= out_ei_in;
      out_rc_ff <= out_rc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_st_ff;
   assign rsp_tdata  = {4'b0, out_rc_ff, out_ei_ff, out_ri_ff};

endmodule

@@ tb/refcounted_hash_cache_with_release_fifo_unit_tb.sv @@
// Self-checking testbench for the reference-counted hash cache with release queue.
// Predicts every response from its own copy of the table, chains and release queue.
// Depends on rhc_pkg and refcounted_hash_cache_with_release_fifo_unit.
`timescale 1ns / 1ps

module refcounted_hash_cache_with_release_fifo_unit_tb;
   import rhc_pkg::*;

   localparam int NSLOT = DEF_SLOTS;
   localparam int NBUCKET = DEF_BUCKETS;
   localparam int NIL = NSLOT;
   localparam int REF_TOP = (1 << DEF_REF_BITS) - 1;

   typedef struct {
      logic              cmd;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      logic [INDEX_W-1:0] idx;
   } request_type;

   typedef struct {
      status_type          st;
      logic [INDEX_W-1:0]  slot;
      logic [INDEX_W-1:0]  victim;
      logic [COUNT_W-1:0]  refs;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [10:0] csr_wdata = '0;

   refcounted_hash_cache_with_release_fifo_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the cache. Null links hold NIL.
   bit                entry_live [NSLOT];
   logic [KEY_W-1:0]  entry_key  [NSLOT];
   logic [HASH_W-1:0] entry_hash [NSLOT];
   int                entry_refs [NSLOT];
   int                chain_link [NSLOT];
   int                bucket_head [NBUCKET];
   int                q_newer [NSLOT];
   int                q_older [NSLOT];
   int                q_newest, q_oldest, q_count;
   int                queue_limit;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int       recent_slots[$];
   bit       failed = 1'b0;
   bit       no_gaps = 1'b0;
   int       phase_id = 0;

   // Unlinks slot i from the release queue.
   function automatic void unqueue(int i);
      int nw, ol;
      nw = q_newer[i];
      ol = q_older[i];
      if (nw < NIL) q_older[nw] = ol; else q_newest = ol;
      if (ol < NIL) q_newer[ol] = nw; else q_oldest = nw;
      q_newer[i] = NIL;
      q_older[i] = NIL;
   endfunction

   // Unlinks slot i from its bucket chain.
   function automatic void unchain(int i);
      int b, cur, prev;
      b = entry_hash[i] % NBUCKET;
      cur = bucket_head[b];
      prev = NIL;
      while (cur < NIL) begin
         if (cur == i) begin
            if (prev < NIL) chain_link[prev] = chain_link[cur];
            else bucket_head[b] = chain_link[cur];
            chain_link[i] = NIL;
            return;
         end
         prev = cur;
         cur = chain_link[cur];
      end
   endfunction

   function automatic answer_type lookup_or_release(request_type r);
      answer_type a;
      int b, cur, last, i, victim;
      a = '{ST_ERROR, '0, '0, '0};
      if (r.cmd == CMD_GET) begin
         b = r.hash % NBUCKET;
         cur = bucket_head[b];
         last = NIL;
         while (cur < NIL) begin
            if (entry_hash[cur] == r.hash && entry_key[cur] == r.key) begin
               a.slot = cur[INDEX_W-1:0];
               if (entry_refs[cur] >= REF_TOP) begin
                  // Count is saturated: nothing changes.
                  a.refs = entry_refs[cur][COUNT_W-1:0];
                  return a;
               end
               if (entry_refs[cur] == 0) begin
                  unqueue(cur);
                  if (q_count > 0) q_count--;
               end
               entry_refs[cur]++;
               a.st = ST_HIT;
               a.refs = entry_refs[cur][COUNT_W-1:0];
               return a;
            end
            last = cur;
            cur = chain_link[cur];
         end
         for (i = 0; i < NSLOT; i++) if (!entry_live[i]) break;
         if (i >= NSLOT) begin
            a.st = ST_FULL;
            return a;
         end
         entry_live[i] = 1'b1;
         entry_key[i] = r.key;
         entry_hash[i] = r.hash;
         entry_refs[i] = 1;
         chain_link[i] = NIL;
         q_newer[i] = NIL;
         q_older[i] = NIL;
         if (last < NIL) chain_link[last] = i; else bucket_head[b] = i;
         a.st = ST_MISS;
         a.slot = i[INDEX_W-1:0];
         a.refs = 1;
         return a;
      end
      i = r.idx;
      if (!entry_live[i] || entry_refs[i] == 0) return a;
      entry_refs[i]--;
      if (entry_refs[i] != 0) begin
         a.st = ST_HELD;
         a.refs = entry_refs[i][COUNT_W-1:0];
         return a;
      end
      // Count reached zero: the entry becomes the newest in the release queue.
      q_newer[i] = NIL;
      q_older[i] = q_newest;
      if (q_newest < NIL) q_newer[q_newest] = i; else q_oldest = i;
      q_newest = i;
      if (q_count < queue_limit) begin
         q_count++;
         a.st = ST_QUEUED;
         return a;
      end
      // Queue is at its limit, so the oldest entry is dropped from the table.
      victim = (q_oldest < NIL) ? q_oldest : i;
      unqueue(victim);
      unchain(victim);
      entry_live[victim] = 1'b0;
      a.st = ST_EVICTED;
      a.victim = victim[INDEX_W-1:0];
      return a;
   endfunction

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         entry_live[i] = 1'b0;
         entry_refs[i] = 0;
         chain_link[i] = NIL;
         q_newer[i] = NIL;
         q_older[i] = NIL;
      end
      for (int b = 0; b < NBUCKET; b++) bucket_head[b] = NIL;
      q_newest = NIL;
      q_oldest = NIL;
      q_count = 0;
      queue_limit = QUEUE_LIMIT_RESET;
   end

   // Request driver: a random gap before each request, then hold until accepted.
   int send_gap = 0;
   always @(posedge clock) begin
      request_type r;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            r.cmd = req_tuser;
            r.key = req_tdata[63:0];
            r.hash = req_tdata[95:64];
            r.idx = req_tdata[105:96];
            expected_answers.push_back(lookup_or_release(r));
            next_valid = 1'b0;
            send_gap = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               r = pending_requests.pop_front();
               req_tuser <= r.cmd;
               req_tdata <= {6'b0, r.idx, r.hash, r.key};
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response monitor: random stalls, plus one long hold-off so the block backs up.
   int take_gap = 0;
   int long_hold = 0;
   bit held_once = 1'b0;
   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_tuser !== e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_tuser);
                  failed = 1'b1;
               end
               if (rsp_tdata[9:0] !== e.slot) begin
                  $error("result_index: expected %0d, got %0d", e.slot, rsp_tdata[9:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[19:10] !== e.victim) begin
                  $error("evicted_index: expected %0d, got %0d", e.victim,
                         rsp_tdata[19:10]);
                  failed = 1'b1;
               end
               if (rsp_tdata[35:20] !== e.refs) begin
                  $error("reference_count: expected %0d, got %0d", e.refs,
                         rsp_tdata[35:20]);
                  failed = 1'b1;
               end
               if (e.st == ST_HIT || e.st == ST_MISS) begin
                  recent_slots.push_back(e.slot);
                  if (recent_slots.size() > 32) void'(recent_slots.pop_front());
               end
            end
            take_gap = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (phase_id == 3 && !held_once) begin
            held_once = 1'b1;
            long_hold = 400;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #100_000_000;
      $display("refcounted_hash_cache_with_release_fifo_unit: mismatch");
      $finish;
   end

   // Stimulus helpers. The queue is kept short so random releases can pick
   // slots that the block has just reported.
   task automatic send(input logic cmd, input logic [63:0] key, input logic [31:0] hash,
                       input logic [9:0] idx);
      while (pending_requests.size() >= 4) @(posedge clock);
      pending_requests.push_back('{cmd, key, hash, idx});
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_requests.size() != 0 || expected_answers.size() != 0 || req_tvalid);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_limit(input logic [10:0] value);
      drain();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      queue_limit = value;
      csr_valid <= 1'b0;
   endtask

   // Mixed traffic over a small pool of keys whose hashes share a few buckets,
   // with some fresh keys and some releases of arbitrary slots.
   logic [63:0] pool_key [48];
   logic [31:0] pool_hash [48];
   logic [63:0] fill_key [1030];
   logic [31:0] fill_hash [1030];

   task automatic mixed_traffic(input int count);
      int p;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 9) == 0)
               send(CMD_GET, {$urandom, $urandom}, $urandom, 10'($urandom));
            else begin
               p = $urandom_range(0, 47);
               send(CMD_GET, pool_key[p], pool_hash[p], 10'($urandom));
            end
         end else if (recent_slots.size() > 0 && $urandom_range(0, 3) != 0) begin
            send(CMD_RELEASE, {$urandom, $urandom}, $urandom,
                 10'(recent_slots[$urandom_range(0, recent_slots.size() - 1)]));
         end else begin
            send(CMD_RELEASE, {$urandom, $urandom}, $urandom,
                 10'($urandom_range(0, 1023)));
         end
      end
   endtask

   initial begin
      for (int p = 0; p < 48; p++) begin
         pool_key[p] = {$urandom, $urandom};
         pool_hash[p] = {$urandom_range(0, 255) << 8} | ($urandom_range(0, 5) * 8'd37);
      end
      // A few pool entries share a hash but not a key.
      for (int p = 40; p < 48; p++) pool_hash[p] = pool_hash[p - 40];
      for (int n = 0; n < 1030; n++) begin
         fill_key[n] = {4'hF, 28'(n), $urandom};
         fill_hash[n] = $urandom;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of key and hash, chains in one bucket, every status but full and evicted.
      send(CMD_GET, '0, '0, '0);
      send(CMD_GET, '1, '1, '1);
      send(CMD_GET, 64'd5, '0, '0);
      send(CMD_GET, '0, 32'd256, '0);
      send(CMD_GET, '0, '0, '0);
      send(CMD_RELEASE, '1, '1, 10'd0);
      send(CMD_RELEASE, '0, '0, 10'd0);
      send(CMD_GET, '0, '0, '0);
      send(CMD_RELEASE, '0, '0, 10'd0);
      send(CMD_RELEASE, '0, '0, 10'd0);
      send(CMD_RELEASE, '0, '0, 10'd1023);
      send(CMD_RELEASE, '0, '0, 10'd1);
      send(CMD_RELEASE, '0, '0, 10'd2);
      send(CMD_RELEASE, '0, '0, 10'd3);

      // Limit zero: every zero-count release evicts; with an empty queue the
      // released entry goes itself.
      set_limit(11'd0);
      send(CMD_GET, 64'd9, 32'd7, '0);
      for (int n = 0; n < 5; n++) send(CMD_RELEASE, '0, '0, 10'(n));
      send(CMD_GET, 64'd9, 32'd7, '0);
      send(CMD_RELEASE, '0, '0, 10'd0);

      // Fill the table until it reports full, with no idling on either side,
      // then release part of it.
      set_limit(11'd1024);
      no_gaps = 1'b1;
      for (int n = 0; n < 1030; n++) send(CMD_GET, fill_key[n], fill_hash[n], '0);
      drain();
      no_gaps = 1'b0;
      for (int n = 0; n < 300; n++) send(CMD_RELEASE, '0, '0, 10'(n));

      // Limit far below the queued count: hits pull entries back out of the
      // queue, and each later zero-count release evicts the oldest.
      set_limit(11'd2);
      for (int n = 0; n < 40; n++) send(CMD_GET, fill_key[n * 7], fill_hash[n * 7], '0);
      phase_id = 3;
      mixed_traffic(200);
      set_limit(11'd1);
      mixed_traffic(150);
      set_limit(11'd0);
      mixed_traffic(100);
      set_limit(11'd1024);
      mixed_traffic(150);
      drain();

      if (!failed)
         $display("refcounted_hash_cache_with_release_fifo_unit: match");
      else
         $display("refcounted_hash_cache_with_release_fifo_unit: mismatch");
      $finish;
   end

endmodule
